// ===== rtl/idff_pkg.sv =====
// shared types and constants for the integer decimal field formatter
`default_nettype none

package idff_pkg;

  localparam int FIELD_MAX_DEF = 64;
  localparam int VALUE_W       = 32;
  localparam int WIDTH_W       = 7;
  localparam int PREC_W        = 6;
  localparam int POS_W         = 7;
  localparam int DIGITS        = 10;
  localparam int DIG_W         = 4;
  localparam int BCD_W         = DIGITS * DIG_W;
  localparam int NLEN_W        = 4;
  localparam int CHAR_W        = 8;

  // input tdata layout, lowest bit first
  localparam int IN_VALUE_LSB = 0;
  localparam int IN_WIDTH_LSB = IN_VALUE_LSB + VALUE_W;
  localparam int IN_PREC_LSB  = IN_WIDTH_LSB + WIDTH_W;
  localparam int IN_PG_BIT    = IN_PREC_LSB + PREC_W;
  localparam int IN_ZPAD_BIT  = IN_PG_BIT + 1;
  localparam int IN_LEFT_BIT  = IN_ZPAD_BIT + 1;
  localparam int IN_TDATA_W   = ((IN_LEFT_BIT + 1 + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP1,
    ST_PREP2,
    ST_PREP3,
    ST_EMIT
  } idff_state_t;

  typedef struct packed {
    logic load;
    logic prep1;
    logic prep2;
    logic prep3;
    logic emit;
  } idff_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic empty;
    logic last;
    logic out_free;
  } idff_sts_t;

endpackage

`default_nettype wire

// ===== rtl/idff_bcd.sv =====
// iterative binary to bcd converter, one shift-and-adjust step per cycle
`default_nettype none

module idff_bcd import idff_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [VALUE_W-1:0] bin_in,
  output logic                    done,
  output logic [BCD_W-1:0]        bcd
);

  localparam int CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   adj;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  // add three to every digit of five or more before the shift
  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*DIG_W +: DIG_W] >= 4'd5) begin
        adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= bin_in;
      bcd_r <= '0;
    end else if (busy_r) begin
      bcd_r <= {adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      bin_r <= {bin_r[VALUE_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

`default_nettype wire

// ===== rtl/idff_dp.sv =====
// datapath: operand registers, field layout arithmetic, character select and output register
`default_nettype none

module idff_dp import idff_pkg::*; #(
  parameter int FIELD_MAX = FIELD_MAX_DEF,
  localparam int LEN_W = $clog2(FIELD_MAX + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire idff_cmd_t          cmd,
  output idff_sts_t               sts,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               is_signed,
  input  wire logic [WIDTH_W-1:0] width,
  input  wire logic [PREC_W-1:0]  precision,
  input  wire logic               precision_given,
  input  wire logic               zero_pad,
  input  wire logic               left_justify,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [CHAR_W-1:0]       out_char,
  output logic                    out_last,
  output logic [LEN_W-1:0]        out_len
);

  // operand registers
  logic               neg_r, zpad_r, left_r, pg_r, magz_r;
  logic [PREC_W-1:0]  p_r;
  logic [POS_W-1:0]   wsat_r;

  // layout registers
  logic [NLEN_W-1:0]  nlen_r;
  logic               supp_r;
  logic [POS_W-1:0]   pz_r, fix_r;
  logic [POS_W-1:0]   b0_r, b1_r, b2_r, b3_r, b4_r, n_r;
  logic [POS_W-1:0]   k_r;

  // output register
  logic               ov_r;
  logic [CHAR_W-1:0]  ochar_r;
  logic               olast_r;
  logic [LEN_W-1:0]   olen_r;

  logic               neg_in;
  logic [VALUE_W-1:0] mag_in;
  logic [POS_W-1:0]   wsat_in;
  logic               conv_done;
  logic [BCD_W-1:0]   bcd;
  logic [DIG_W-1:0]   digs [DIGITS];
  logic [NLEN_W-1:0]  nlen_c;
  logic [POS_W-1:0]   nlen_ext, p_ext, pz_c, fix_c;
  logic [POS_W-1:0]   pad_c, lead_c, b0_c, b1_c, b2_c, b3_c, b4_c, total_c, n_c;
  logic [POS_W-1:0]   di_full;
  logic [DIG_W-1:0]   di, digit;
  logic [CHAR_W-1:0]  pad_ch, ch_c;
  logic               last_c, out_free;

  assign neg_in  = is_signed & value[VALUE_W-1];
  assign mag_in  = neg_in ? (~value + 1'b1) : value;
  assign wsat_in = (int'(width) > FIELD_MAX) ? POS_W'(FIELD_MAX) : width;

  idff_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.load),
    .bin_in (mag_in),
    .done   (conv_done),
    .bcd    (bcd)
  );

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      digs[i] = bcd[i*DIG_W +: DIG_W];
    end
  end

  // number of significant digits, at least one
  always_comb begin
    nlen_c = NLEN_W'(1);
    for (int i = 0; i < DIGITS; i++) begin
      if (digs[i] != '0) begin
        nlen_c = NLEN_W'(i + 1);
      end
    end
  end

  assign nlen_ext = POS_W'(nlen_r);
  assign p_ext    = POS_W'(p_r);
  assign pz_c     = (p_ext > nlen_ext) ? (p_ext - nlen_ext) : '0;
  assign fix_c    = POS_W'(neg_r) + ((p_ext > nlen_ext) ? p_ext : nlen_ext);

  assign pad_c   = (wsat_r > fix_r) ? (wsat_r - fix_r) : '0;
  assign lead_c  = left_r ? '0 : pad_c;
  assign b0_c    = POS_W'(neg_r & zpad_r);
  assign b1_c    = b0_c + lead_c;
  assign b2_c    = b1_c + POS_W'(neg_r & ~zpad_r);
  assign b3_c    = b2_c + pz_r;
  assign b4_c    = b3_c + (supp_r ? '0 : nlen_ext);
  assign total_c = fix_r + pad_c;
  assign n_c     = (int'(total_c) > FIELD_MAX) ? POS_W'(FIELD_MAX) : total_c;

  // digits go out most significant first
  assign di_full = b4_r - POS_W'(1) - k_r;
  assign di      = di_full[DIG_W-1:0];
  assign digit   = (int'(di) < DIGITS) ? digs[di] : '0;
  assign pad_ch  = zpad_r ? CH_ZERO : CH_SPACE;

  always_comb begin
    if (k_r < b0_r) begin
      ch_c = CH_MINUS;
    end else if (k_r < b1_r) begin
      ch_c = pad_ch;
    end else if (k_r < b2_r) begin
      ch_c = CH_MINUS;
    end else if (k_r < b3_r) begin
      ch_c = CH_ZERO;
    end else if (k_r < b4_r) begin
      ch_c = CH_ZERO + CHAR_W'(digit);
    end else begin
      ch_c = CH_SPACE;
    end
  end

  assign last_c   = (k_r == n_r - POS_W'(1));
  assign out_free = ~ov_r | out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= neg_in;
      zpad_r <= zero_pad;
      left_r <= left_justify;
      pg_r   <= precision_given;
      p_r    <= precision_given ? precision : '0;
      magz_r <= (value == '0);
      wsat_r <= wsat_in;
    end
    if (cmd.prep1) begin
      nlen_r <= nlen_c;
    end
    if (cmd.prep2) begin
      supp_r <= pg_r & (p_r == '0) & magz_r;
      pz_r   <= pz_c;
      fix_r  <= (pg_r & (p_r == '0) & magz_r) ? '0 : fix_c;
    end
    if (cmd.prep3) begin
      b0_r <= b0_c;
      b1_r <= b1_c;
      b2_r <= b2_c;
      b3_r <= b3_c;
      b4_r <= b4_c;
      n_r  <= n_c;
    end
    if (cmd.emit) begin
      ochar_r <= ch_c;
      olast_r <= last_c;
      olen_r  <= LEN_W'(n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      k_r  <= '0;
    end else begin
      if (cmd.prep3) begin
        k_r <= '0;
      end else if (cmd.emit) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign sts.conv_done = conv_done;
  assign sts.empty     = (n_r == '0);
  assign sts.last      = last_c;
  assign sts.out_free  = out_free;

  assign out_valid = ov_r;
  assign out_char  = ochar_r;
  assign out_last  = olast_r;
  assign out_len   = olen_r;

endmodule

`default_nettype wire

// ===== rtl/idff_ctrl.sv =====
// controller state machine: conversion, layout steps and character emission
`default_nettype none

module idff_ctrl import idff_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire idff_sts_t sts,
  output idff_cmd_t      cmd
);

  idff_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_done) state_nxt = ST_PREP1;
      end
      ST_PREP1: state_nxt = ST_PREP2;
      ST_PREP2: state_nxt = ST_PREP3;
      ST_PREP3: state_nxt = ST_EMIT;
      ST_EMIT: begin
        // a field with no characters ends at once
        if (sts.empty || (sts.out_free && sts.last)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PREP1: cmd.prep1 = 1'b1;
      ST_PREP2: cmd.prep2 = 1'b1;
      ST_PREP3: cmd.prep3 = 1'b1;
      ST_EMIT: begin
        cmd.emit = ~sts.empty & sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/integer_decimal_field_formatter.sv =====
// Printf-style decimal integer field formatter, top level.
// An item on the in_ channel carries a 32-bit value and its format flags;
// the block answers with the formatted field on the out_ channel, one ASCII
// character per item, tlast on the final character. Every output item also
// carries the total field length. A zero value with an explicit zero
// precision and a zero width gives no output items at all.
// Steps: after an item is accepted the value is converted to decimal by a
// bit-serial double-dabble unit, then the layout steps PREP1, PREP2 and
// PREP3 work out the field layout, then characters leave at one per cycle
// while the receiver does not stall. A field holds up to FIELD_MAX
// characters; the next item is taken only once the field is finished.
// in_tready is high only while no item is in work; the last character may
// still sit in the output register while the next item is taken.
// When the receiver holds out_tready low, the output register holds its
// character and emission pauses; nothing is dropped.
// Reset (rst_n low at a clock edge) returns the controller to idle, empties
// the output register and abandons any item in work.
`default_nettype none

module integer_decimal_field_formatter import idff_pkg::*; #(
  parameter int FIELD_MAX = FIELD_MAX_DEF,
  localparam int LEN_W = $clog2(FIELD_MAX + 1),
  localparam int OUT_TDATA_W = ((CHAR_W + LEN_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // value, width, precision, precision_given, zero_pad, left_justify
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // is_signed
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // character, field_length
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  idff_cmd_t         cmd;
  idff_sts_t         sts;
  logic [CHAR_W-1:0] out_char;
  logic [LEN_W-1:0]  out_len;

  idff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  idff_dp #(
    .FIELD_MAX (FIELD_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .value           (in_tdata[IN_VALUE_LSB +: VALUE_W]),
    .is_signed       (in_tuser),
    .width           (in_tdata[IN_WIDTH_LSB +: WIDTH_W]),
    .precision       (in_tdata[IN_PREC_LSB +: PREC_W]),
    .precision_given (in_tdata[IN_PG_BIT]),
    .zero_pad        (in_tdata[IN_ZPAD_BIT]),
    .left_justify    (in_tdata[IN_LEFT_BIT]),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_char        (out_char),
    .out_last        (out_tlast),
    .out_len         (out_len)
  );

  assign out_tdata = OUT_TDATA_W'({out_len, out_char});

  // an accepted item keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input open right after an accepted item");

  // a presented character belongs to a field of one to FIELD_MAX characters
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_len != '0) && (int'(out_len) <= FIELD_MAX))
    else $error("field length out of range");

  // the conversion unit finishes only while an item is in work
  a_conv_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    sts.conv_done |-> !in_tready)
    else $error("conversion done while idle");

endmodule

`default_nettype wire
